/* rtl/core/ccp_pkg.sv */
// ----------------------------------------------------------------------------
// ccp_pkg - constant pool parser shared definitions
// Tag codes, result kinds, parser phases and the per-tag payload length.
// ----------------------------------------------------------------------------
package ccp_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned IdxW    = 16;
  localparam int unsigned ValW    = 64;
  localparam int unsigned KindW   = 3;
  localparam int unsigned HighWordShift = 32;

  // constant tags
  localparam logic [7:0] TAG_UTF8           = 8'd1;
  localparam logic [7:0] TAG_INTEGER        = 8'd3;
  localparam logic [7:0] TAG_FLOAT          = 8'd4;
  localparam logic [7:0] TAG_LONG           = 8'd5;
  localparam logic [7:0] TAG_DOUBLE         = 8'd6;
  localparam logic [7:0] TAG_CLASS          = 8'd7;
  localparam logic [7:0] TAG_STRING         = 8'd8;
  localparam logic [7:0] TAG_FIELDREF       = 8'd9;
  localparam logic [7:0] TAG_METHODREF      = 8'd10;
  localparam logic [7:0] TAG_IFMETHODREF    = 8'd11;
  localparam logic [7:0] TAG_NAMEANDTYPE    = 8'd12;
  localparam logic [7:0] TAG_METHODHANDLE   = 8'd15;
  localparam logic [7:0] TAG_METHODTYPE     = 8'd16;
  localparam logic [7:0] TAG_DYNAMIC        = 8'd17;
  localparam logic [7:0] TAG_INVOKEDYNAMIC  = 8'd18;
  localparam logic [7:0] TAG_MODULE         = 8'd19;
  localparam logic [7:0] TAG_PACKAGE        = 8'd20;

  typedef enum logic [KindW-1:0] {
    KIND_ENTRY    = 3'd0,
    KIND_TEXT     = 3'd1,
    KIND_EMPTY    = 3'd2,
    KIND_BADCOUNT = 3'd3,
    KIND_BADTAG   = 3'd4
  } kind_t;

  typedef enum logic [5:0] {
    PH_IDLE     = 6'b000001,
    PH_CNT_LO   = 6'b000010,
    PH_TAG      = 6'b000100,
    PH_PAYLOAD  = 6'b001000,
    PH_TEXT_LEN = 6'b010000,
    PH_TEXT     = 6'b100000
  } phase_t;

  // payload bytes after the tag; zero means the tag is not known
  function automatic logic [3:0] payload_len(input logic [7:0] t);
    logic [3:0] n;
    unique case (t)
      TAG_UTF8:                                    n = 4'd2;
      TAG_INTEGER, TAG_FLOAT:                      n = 4'd4;
      TAG_LONG, TAG_DOUBLE:                        n = 4'd8;
      TAG_CLASS, TAG_STRING, TAG_METHODTYPE,
      TAG_MODULE, TAG_PACKAGE:                     n = 4'd2;
      TAG_FIELDREF, TAG_METHODREF, TAG_IFMETHODREF,
      TAG_NAMEANDTYPE, TAG_DYNAMIC,
      TAG_INVOKEDYNAMIC:                           n = 4'd4;
      TAG_METHODHANDLE:                            n = 4'd3;
      default:                                     n = 4'd0;
    endcase
    return n;
  endfunction

endpackage

/* rtl/core/class_constant_pool_parser_top.sv */
// ----------------------------------------------------------------------------
// class_constant_pool_parser_top - byte-serial class-file constant pool parser
// Reads the pool count, then each entry's tag and payload, one byte a cycle while
// s_axis_tready is high, and produces one record per entry and one result per UTF-8 text byte.
// ----------------------------------------------------------------------------
//  channel   dir  tdata                       tuser                 tlast
//  s_axis    in   in_byte                     start_req             -
//  m_axis    out  slot,tag,value,first_index, result_kind,text_last pool_last
//                 second_index,handle_kind,
//                 text_byte
//
//  One byte is taken every cycle while s_axis_tready is high; each request
//  leaves at most one result in the next cycle through a single output
//  register. s_axis_tready falls only while a result waits and m_axis_tready is low.
//  rst clears the parser to idle and empties the output register. A byte with
//  start_req restarts the parser from any phase; bytes before a start are dropped.
// ----------------------------------------------------------------------------
module class_constant_pool_parser_top
  import ccp_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // [7:0] in_byte
  input  logic         s_axis_tuser,   // [0] start_req
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [135:0] m_axis_tdata,   // [15:0] slot, [23:16] tag, [87:24] value,
                                       // [103:88] first_index, [119:104] second_index,
                                       // [127:120] handle_kind, [135:128] text_byte
  output logic [3:0]   m_axis_tuser,   // [2:0] result_kind, [3] text_last
  output logic         m_axis_tlast    // pool_last
);

  phase_t            phase, phase_next;
  logic [IdxW-1:0]   slots_left, slots_left_next;
  logic [IdxW-1:0]   slot_number, slot_number_next;
  logic [ByteW-1:0]  current_tag, current_tag_next;
  logic [IdxW-1:0]   bytes_left, bytes_left_next;
  logic [ValW-1:0]   accumulator, accumulator_next;

  logic              out_valid, out_valid_next;
  kind_t             r_kind, r_kind_next;
  logic [IdxW-1:0]   r_slot, r_slot_next;
  logic [ByteW-1:0]  r_tag, r_tag_next;
  logic [ValW-1:0]   r_value, r_value_next;
  logic [IdxW-1:0]   r_first, r_first_next;
  logic [IdxW-1:0]   r_second, r_second_next;
  logic [ByteW-1:0]  r_refkind, r_refkind_next;
  logic [ByteW-1:0]  r_text, r_text_next;
  logic              r_text_last, r_text_last_next;
  logic              r_pool_last, r_pool_last_next;

  logic              accept;
  logic [ByteW-1:0]  b;
  logic              start;
  logic [ValW-1:0]   acc_shift;
  logic [IdxW-1:0]   bytes_dec;
  logic [IdxW-1:0]   count;
  logic [IdxW-1:0]   used;
  logic              pool_done;
  logic [3:0]        plen;
  logic              emit;

  assign s_axis_tready = !out_valid || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign b             = s_axis_tdata;
  assign start         = s_axis_tuser;
  assign acc_shift     = {accumulator[ValW-ByteW-1:0], b};
  assign bytes_dec     = bytes_left - 16'd1;
  assign count         = {accumulator[7:0], b};
  assign plen          = payload_len(b);
  assign used          = (current_tag == TAG_LONG || current_tag == TAG_DOUBLE) ? 16'd2 : 16'd1;
  assign pool_done     = (slots_left <= used);

  always_comb begin
    phase_next       = phase;
    slots_left_next  = slots_left;
    slot_number_next = slot_number;
    current_tag_next = current_tag;
    bytes_left_next  = bytes_left;
    accumulator_next = accumulator;

    emit             = 1'b0;
    r_kind_next      = KIND_ENTRY;
    r_slot_next      = slot_number;
    r_tag_next       = current_tag;
    r_value_next     = '0;
    r_first_next     = '0;
    r_second_next    = '0;
    r_refkind_next   = '0;
    r_text_next      = '0;
    r_text_last_next = 1'b0;
    r_pool_last_next = 1'b0;

    if (start) begin
      accumulator_next = {{(ValW-ByteW){1'b0}}, b};
      slots_left_next  = '0;
      slot_number_next = '0;
      current_tag_next = '0;
      bytes_left_next  = '0;
      phase_next       = PH_CNT_LO;
    end else begin
      unique case (phase)
        PH_CNT_LO: begin
          accumulator_next = '0;
          if (count == 16'd0) begin
            phase_next  = PH_IDLE;
            emit        = 1'b1;
            r_kind_next = KIND_BADCOUNT;
            r_slot_next = '0;
            r_tag_next  = '0;
          end else if (count == 16'd1) begin
            phase_next       = PH_IDLE;
            emit             = 1'b1;
            r_kind_next      = KIND_EMPTY;
            r_slot_next      = '0;
            r_tag_next       = '0;
            r_pool_last_next = 1'b1;
          end else begin
            slots_left_next  = count - 16'd1;
            slot_number_next = 16'd1;
            phase_next       = PH_TAG;
          end
        end
        PH_TAG: begin
          current_tag_next = b;
          if (plen == 4'd0) begin
            phase_next  = PH_IDLE;
            emit        = 1'b1;
            r_kind_next = KIND_BADTAG;
            r_tag_next  = b;
          end else begin
            accumulator_next = '0;
            bytes_left_next  = {12'd0, plen};
            phase_next       = (b == TAG_UTF8) ? PH_TEXT_LEN : PH_PAYLOAD;
          end
        end
        PH_TEXT_LEN: begin
          accumulator_next = {48'd0, acc_shift[15:0]};
          bytes_left_next  = bytes_dec;
          if (bytes_dec == 16'd0) begin
            emit             = 1'b1;
            r_value_next     = {48'd0, acc_shift[15:0]};
            bytes_left_next  = acc_shift[15:0];
            accumulator_next = '0;
            if (acc_shift[15:0] == 16'd0) begin
              r_pool_last_next = pool_done;
            end else begin
              phase_next = PH_TEXT;
            end
          end
        end
        PH_TEXT: begin
          bytes_left_next = bytes_dec;
          emit            = 1'b1;
          r_kind_next     = KIND_TEXT;
          r_text_next     = b;
          if (bytes_dec == 16'd0) begin
            r_text_last_next = 1'b1;
            r_pool_last_next = pool_done;
          end
        end
        PH_PAYLOAD: begin
          accumulator_next = acc_shift;
          bytes_left_next  = bytes_dec;
          if (bytes_dec == 16'd0) begin
            accumulator_next = '0;
            emit             = 1'b1;
            r_pool_last_next = pool_done;
            unique case (current_tag)
              TAG_INTEGER, TAG_FLOAT:
                r_value_next = {32'd0, acc_shift[HighWordShift-1:0]};
              TAG_LONG, TAG_DOUBLE:
                r_value_next = acc_shift;
              TAG_FIELDREF, TAG_METHODREF, TAG_IFMETHODREF, TAG_NAMEANDTYPE,
              TAG_DYNAMIC, TAG_INVOKEDYNAMIC: begin
                r_first_next  = acc_shift[31:16];
                r_second_next = acc_shift[15:0];
              end
              TAG_METHODHANDLE: begin
                r_refkind_next = acc_shift[23:16];
                r_first_next   = acc_shift[15:0];
              end
              default:
                r_first_next = acc_shift[15:0];
            endcase
          end
        end
        default: phase_next = PH_IDLE;  // idle: stray bytes dropped
      endcase

      // entry completed: step the slot counters
      if (emit && r_kind_next != KIND_BADTAG && r_kind_next != KIND_BADCOUNT &&
          r_kind_next != KIND_EMPTY &&
          (r_kind_next == KIND_ENTRY ? (phase_next != PH_TEXT) : r_text_last_next)) begin
        if (pool_done) begin
          slots_left_next = '0;
          phase_next      = PH_IDLE;
        end else begin
          slots_left_next  = slots_left - used;
          slot_number_next = slot_number + used;
          phase_next       = PH_TAG;
        end
      end
    end

    if (accept) begin
      out_valid_next = emit;
    end else if (m_axis_tready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      slots_left  <= '0;
      slot_number <= '0;
      current_tag <= '0;
      bytes_left  <= '0;
      accumulator <= '0;
      out_valid   <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
      if (accept) begin
        phase       <= phase_next;
        slots_left  <= slots_left_next;
        slot_number <= slot_number_next;
        current_tag <= current_tag_next;
        bytes_left  <= bytes_left_next;
        accumulator <= accumulator_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      r_kind      <= r_kind_next;
      r_slot      <= r_slot_next;
      r_tag       <= r_tag_next;
      r_value     <= r_value_next;
      r_first     <= r_first_next;
      r_second    <= r_second_next;
      r_refkind   <= r_refkind_next;
      r_text      <= r_text_next;
      r_text_last <= r_text_last_next;
      r_pool_last <= r_pool_last_next;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {r_text, r_refkind, r_second, r_first, r_value, r_tag, r_slot};
  assign m_axis_tuser  = {r_text_last, r_kind};
  assign m_axis_tlast  = r_pool_last;

  // text phase is only entered with bytes still to come
  a_text_nonzero: assert property (@(posedge clk) disable iff (rst)
    phase == PH_TEXT |-> bytes_left != 16'd0)
    else $error("text phase with no bytes left");

  a_start_restarts: assert property (@(posedge clk) disable iff (rst)
    accept && start |=> phase == PH_CNT_LO)
    else $error("start request did not restart parser");

  a_err_not_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (r_kind == KIND_BADCOUNT || r_kind == KIND_BADTAG) |-> !r_pool_last)
    else $error("error result flagged as pool end");

  a_text_last_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid && r_text_last |-> r_kind == KIND_TEXT)
    else $error("text_last on non-text result");

  a_pool_end_idle: assert property (@(posedge clk) disable iff (rst)
    accept && emit && r_pool_last_next |=> phase == PH_IDLE && slots_left == 16'd0)
    else $error("parser not idle after pool end");

endmodule
